>>> sv/clock_tree_frequency_calc_unit_assert.svh
// Assertion macros for the clock tree frequency calculator.
`ifndef CLOCK_TREE_FREQUENCY_CALC_UNIT_ASSERT_SVH
`define CLOCK_TREE_FREQUENCY_CALC_UNIT_ASSERT_SVH

// Implication checked every clock, idle during reset.
`define CTFC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CTFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/ctfc_pkg.sv
// Package: types, constants and decoders of the clock tree frequency calculator.
`default_nettype none
package ctfc_pkg;

  localparam int OscW  = 26;
  localparam int WordW = 32;
  localparam int NumW  = 28;
  localparam int DivW  = 9;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_M_ZERO   = 2'd1,
    ST_R_UNSUP  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  localparam logic [1:0] REG_HSE   = 2'd0;
  localparam logic [1:0] REG_HSI   = 2'd1;
  localparam logic [1:0] REG_PLLR  = 2'd2;

  localparam logic [1:0] SW_HSI  = 2'd0;
  localparam logic [1:0] SW_HSE  = 2'd1;
  localparam logic [1:0] SW_PLLP = 2'd2;
  localparam logic [1:0] SW_PLLR = 2'd3;

  localparam logic [OscW-1:0] HSE_RESET = 26'd25000000;
  localparam logic [OscW-1:0] HSI_RESET = 26'd16000000;

  typedef struct packed {
    logic [OscW-1:0] base_hz;
    logic            pll_sel;
    status_t         status;
    logic [8:0]      n;
    logic [3:0]      ahb_sh;
    logic [2:0]      apb1_sh;
    logic [2:0]      apb2_sh;
    logic [OscW-1:0] pll_input_hz;
    logic [9:0]      ahb_div;
    logic [4:0]      apb1_div;
    logic [4:0]      apb2_div;
    logic [2:0]      mco1_div;
    logic [2:0]      mco2_div;
    logic [4:0]      rtc_prescale;
  } ctx_t;

  function automatic logic [3:0] ahb_shift(logic [3:0] code);
    if (!code[3]) return 4'd0;
    return code[2] ? 4'({1'b0, code[2:0]} + 4'd2) : 4'({1'b0, code[2:0]} + 4'd1);
  endfunction

  function automatic logic [2:0] apb_shift(logic [2:0] code);
    return code[2] ? 3'({1'b0, code[1:0]} + 3'd1) : 3'd0;
  endfunction

  function automatic logic [2:0] mco_div(logic [2:0] code);
    return code[2] ? 3'({1'b0, code[1:0]} + 3'd2) : 3'd1;
  endfunction

endpackage
`default_nettype wire

>>> sv/ctfc_if.sv
// Channel interfaces: input snapshot, result word, configuration write.
`default_nettype none
interface ctfc_item_if;
  logic                        valid;
  logic                        ready;
  logic [ctfc_pkg::WordW-1:0]  clock_config_word;
  logic [ctfc_pkg::WordW-1:0]  pll_config_word;
  modport source (output valid, clock_config_word, pll_config_word, input ready);
  modport sink (input valid, clock_config_word, pll_config_word, output ready);
endinterface

interface ctfc_result_if;
  logic                       valid;
  logic                       ready;
  logic [ctfc_pkg::WordW-1:0] sys_hz;
  logic [ctfc_pkg::WordW-1:0] hclk_hz;
  logic [ctfc_pkg::WordW-1:0] pclk1_hz;
  logic [ctfc_pkg::WordW-1:0] pclk2_hz;
  logic [ctfc_pkg::OscW-1:0]  pll_input_hz;
  logic [9:0]                 ahb_div;
  logic [4:0]                 apb1_div;
  logic [4:0]                 apb2_div;
  logic [2:0]                 mco1_div;
  logic [2:0]                 mco2_div;
  logic [4:0]                 rtc_prescale;
  logic [1:0]                 status;
  modport source (output valid, sys_hz, hclk_hz, pclk1_hz, pclk2_hz, pll_input_hz, ahb_div,
    apb1_div, apb2_div, mco1_div, mco2_div, rtc_prescale, status, input ready);
  modport sink (input valid, sys_hz, hclk_hz, pclk1_hz, pclk2_hz, pll_input_hz, ahb_div,
    apb1_div, apb2_div, mco1_div, mco2_div, rtc_prescale, status, output ready);
endinterface

interface ctfc_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                addr;
  logic [ctfc_pkg::OscW-1:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface
`default_nettype wire

>>> sv/clock_tree_frequency_calc_unit.sv
// Top level: pipelined clock tree frequency calculator.
//   channel     dir  word
//   cfg         in   addr 0 hse_hz, 1 hsi_hz, 2 pllr_present; data
//   item_in     in   clock_config_word, pll_config_word
//   result_out  out  frequencies, decoded dividers, status
// One word per cycle while the output word does not wait; stages are decode, 7 divider stages
// at 4 quotient bits each, multiply, output. (src/M)/P is one divide by M*P.
// rst (synchronous) clears valids and reloads oscillator registers.
// Stall: whole pipe holds while the output word waits; cfg always ready.
`default_nettype none
module clock_tree_frequency_calc_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  ctfc_cfg_if.sink         cfg,
  ctfc_item_if.sink        item_in,
  ctfc_result_if.source    result_out
);
  import ctfc_pkg::*;

  localparam int NDiv = NumW / 4;

  logic [OscW-1:0] hse_hz;
  logic [OscW-1:0] hsi_hz;
  logic            pllr_present;

  logic advance;

  logic            dv   [0:NDiv];
  logic [DivW-1:0] drem [0:NDiv];
  logic [NumW-1:0] dnum [0:NDiv];
  logic [DivW-1:0] dd   [0:NDiv];
  ctx_t            dctx [0:NDiv];

  logic        mv;
  logic [34:0] prod;
  ctx_t        mctx;

  logic            ov;
  logic [WordW-1:0] sys_next;
  logic [WordW-1:0] hclk_next;
  status_t          status_next;
  ctx_t             octx;
  logic [WordW-1:0] sys_hz, hclk_hz, pclk1_hz, pclk2_hz;
  status_t          status_q;

  // decode stage inputs
  logic [1:0] sws;
  logic [5:0] m;
  logic [2:0] r;
  logic [3:0] div2;
  logic [OscW-1:0] src;
  ctx_t ctx_next;

  function automatic logic [DivW+NumW-1:0] div4(logic [DivW-1:0] rem_in,
                                                  logic [NumW-1:0] num_in,
                                                  logic [DivW-1:0] d);
    logic [DivW:0]   t;
    logic [DivW-1:0] rr;
    logic [NumW-1:0] q;
    rr = rem_in;
    q  = num_in;
    for (int i = 0; i < 4; i++) begin
      t = {rr, q[NumW-1]};
      q = {q[NumW-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        rr   = DivW'(t - {1'b0, d});
        q[0] = 1'b1;
      end else begin
        rr = t[DivW-1:0];
      end
    end
    return {rr, q};
  endfunction

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hse_hz       <= HSE_RESET;
      hsi_hz       <= HSI_RESET;
      pllr_present <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.addr)
        REG_HSE:  hse_hz       <= cfg.data;
        REG_HSI:  hsi_hz       <= cfg.data;
        REG_PLLR: pllr_present <= cfg.data[0];
        default: ;
      endcase
    end
  end

  assign advance       = !ov || result_out.ready;
  assign item_in.ready = advance;

  always_comb begin
    sws  = item_in.clock_config_word[3:2];
    m    = item_in.pll_config_word[5:0];
    r    = item_in.pll_config_word[30:28];
    src  = item_in.pll_config_word[22] ? hse_hz : hsi_hz;
    div2 = (sws == SW_PLLR) ? {1'b0, r}
                            : 4'({1'b0, item_in.pll_config_word[17:16], 1'b0} + 4'd2);
    ctx_next.base_hz      = (sws == SW_HSE) ? hse_hz : hsi_hz;
    ctx_next.pll_sel      = sws[1];
    ctx_next.n            = item_in.pll_config_word[14:6];
    ctx_next.ahb_sh       = ahb_shift(item_in.clock_config_word[7:4]);
    ctx_next.apb1_sh      = apb_shift(item_in.clock_config_word[12:10]);
    ctx_next.apb2_sh      = apb_shift(item_in.clock_config_word[15:13]);
    ctx_next.pll_input_hz = src;
    ctx_next.ahb_div      = 10'(11'd1 << ctx_next.ahb_sh);
    ctx_next.apb1_div     = 5'(6'd1 << ctx_next.apb1_sh);
    ctx_next.apb2_div     = 5'(6'd1 << ctx_next.apb2_sh);
    ctx_next.mco1_div     = mco_div(item_in.clock_config_word[26:24]);
    ctx_next.mco2_div     = mco_div(item_in.clock_config_word[29:27]);
    ctx_next.rtc_prescale = item_in.clock_config_word[20:16];
    if (sws == SW_PLLR && (!pllr_present || r == 3'd0)) begin
      ctx_next.status = ST_R_UNSUP;
    end else if (sws[1] && m == 6'd0) begin
      ctx_next.status = ST_M_ZERO;
    end else begin
      ctx_next.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (advance) begin
      dv[0] <= item_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      drem[0] <= '0;
      dnum[0] <= NumW'(src);
      dd[0]   <= DivW'(m) * DivW'(div2);
      dctx[0] <= ctx_next;
    end
  end

  for (genvar k = 1; k <= NDiv; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k] <= 1'b0;
      end else if (advance) begin
        dv[k] <= dv[k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (advance) begin
        {drem[k], dnum[k]} <= div4(drem[k-1], dnum[k-1], dd[k-1]);
        dd[k]   <= dd[k-1];
        dctx[k] <= dctx[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= 1'b0;
    end else if (advance) begin
      mv <= dv[NDiv];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      prod <= 35'(dnum[NDiv][OscW-1:0]) * 35'(dctx[NDiv].n);
      mctx <= dctx[NDiv];
    end
  end

  always_comb begin
    status_next = mctx.status;
    if (!mctx.pll_sel) begin
      sys_next = WordW'(mctx.base_hz);
    end else if (mctx.status != ST_OK) begin
      sys_next = '0;
    end else begin
      sys_next = prod[WordW-1:0];
      if (|prod[34:WordW]) status_next = ST_OVERFLOW;
    end
    hclk_next = sys_next >> mctx.ahb_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (advance) begin
      ov <= mv;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sys_hz   <= sys_next;
      hclk_hz  <= hclk_next;
      pclk1_hz <= hclk_next >> mctx.apb1_sh;
      pclk2_hz <= hclk_next >> mctx.apb2_sh;
      status_q <= status_next;
      octx     <= mctx;
    end
  end

  assign result_out.valid        = ov;
  assign result_out.sys_hz       = sys_hz;
  assign result_out.hclk_hz      = hclk_hz;
  assign result_out.pclk1_hz     = pclk1_hz;
  assign result_out.pclk2_hz     = pclk2_hz;
  assign result_out.pll_input_hz = octx.pll_input_hz;
  assign result_out.ahb_div      = octx.ahb_div;
  assign result_out.apb1_div     = octx.apb1_div;
  assign result_out.apb2_div     = octx.apb2_div;
  assign result_out.mco1_div     = octx.mco1_div;
  assign result_out.mco2_div     = octx.mco2_div;
  assign result_out.rtc_prescale = octx.rtc_prescale;
  assign result_out.status       = status_q;

`include "clock_tree_frequency_calc_unit_assert.svh"

  `CTFC_ASSERT_IMP(a_err_zero, ov && (status_q == ST_M_ZERO || status_q == ST_R_UNSUP), sys_hz == '0, "error word with nonzero sys_hz")
  `CTFC_ASSERT_IMP(a_ahb_pow2, ov, $onehot(octx.ahb_div), "AHB divider not a power of two")
  `CTFC_ASSERT_NEXT(a_enter, item_in.valid && item_in.ready, dv[0], "accepted word not in decode stage")
  `CTFC_ASSERT_IMP(a_hclk_le, ov, hclk_hz <= sys_hz, "hclk above sys clock")

endmodule
`default_nettype wire
